FILE: design/aml2asl_pkg.sv
// ----------------------------------------------------------------------------
// aml2asl_pkg
// Shared types and constants for the AML name path to ASL text decoder.
// ----------------------------------------------------------------------------
package aml2asl_pkg;

  // Fixed format constants
  localparam int unsigned NAME_SEG_LEN = 4;
  localparam int unsigned MAX_RES      = 6;
  localparam logic [7:0]  MAX_CARETS   = 8'd255;
  localparam logic [10:0] LEN_MAX      = 11'd2047;

  // Special path bytes
  localparam logic [7:0] CH_ROOT  = 8'h5C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DUAL  = 8'h2E;
  localparam logic [7:0] CH_MULTI = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Parse phases
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_ROOTS  = 3'd1;
  localparam logic [2:0] PH_CARETS = 3'd2;
  localparam logic [2:0] PH_COUNT  = 3'd3;
  localparam logic [2:0] PH_SEGS   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // Parser state carried from one word to the next
  typedef struct packed {
    logic [2:0]                  phase;
    logic [7:0]                  caret_count;
    logic [7:0]                  segments_left;
    logic [2:0]                  segment_fill;
    logic [NAME_SEG_LEN-2:0][7:0] seg_buf;
    logic [10:0]                 emitted_count;
    logic                        first_seg;
    logic                        error;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:         PH_PREFIX,
    caret_count:   8'd0,
    segments_left: 8'd0,
    segment_fill:  3'd0,
    seg_buf:       '0,
    emitted_count: 11'd0,
    first_seg:     1'b1,
    error:         1'b0
  };

  // Group of result words produced by one input word
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] chars;
    logic [2:0]              count;
    logic                    fin;
    logic                    status;
    logic [10:0]             length;
  } group_t;

  // Segment byte check: leading byte A-Z or '_', others also 0-9
  function automatic logic byte_ok(input logic [7:0] b, input logic leading);
    logic alpha;
    logic digit;
    alpha = ((b >= CH_A) && (b <= CH_Z)) || (b == CH_UNDER);
    digit = (b >= CH_0) && (b <= CH_9);
    return alpha || (!leading && digit);
  endfunction

endpackage

FILE: design/aml2asl_step.sv
// ----------------------------------------------------------------------------
// aml2asl_step
// Next-state and result logic for one path byte: parses root marks, carets,
// name prefixes and segments, and builds the group of ASL characters.
// ----------------------------------------------------------------------------
module aml2asl_step
  import aml2asl_pkg::*;
(
  input  state_t      st,
  input  logic [7:0]  path_byte,
  input  logic        end_of_path,
  input  logic        no_byte,
  output state_t      st_next,
  output group_t      grp
);

  logic                  do_head;
  logic                  do_seg;
  logic                  do_caret;
  logic [2:0]            n;
  logic [2:0]            trim_len;
  logic [NAME_SEG_LEN-1:0][7:0] seg_full;
  logic [11:0]           sum;
  logic [10:0]           emitted;
  logic                  bad;
  logic [10:0]           len;

  always_comb begin
    st_next  = st;
    grp      = '0;
    n        = 3'd0;
    do_head  = 1'b0;
    do_seg   = 1'b0;
    do_caret = 1'b0;
    trim_len = 3'd0;
    seg_full = '0;
    sum      = '0;
    emitted  = '0;
    bad      = 1'b0;
    len      = '0;

    // Classify the byte by phase
    if (!no_byte && !st.error) begin
      unique case (st.phase)
        PH_PREFIX: begin
          if (path_byte == CH_ROOT) begin
            grp.chars[n] = CH_ROOT;
            n = n + 3'd1;
            st_next.phase = PH_ROOTS;
          end else if (path_byte == CH_CARET) begin
            do_caret = 1'b1;
          end else begin
            do_head = 1'b1;
          end
        end
        PH_ROOTS: begin
          if (path_byte != CH_ROOT) do_head = 1'b1;
        end
        PH_CARETS: begin
          if (path_byte == CH_CARET) do_caret = 1'b1;
          else do_head = 1'b1;
        end
        PH_COUNT: begin
          if (path_byte == CH_NUL) begin
            st_next.error = 1'b1;
          end else begin
            st_next.segments_left = path_byte;
            st_next.segment_fill  = 3'd0;
            st_next.phase         = PH_SEGS;
          end
        end
        PH_SEGS: begin
          if (path_byte == CH_NUL) st_next.error = 1'b1;
          else do_seg = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Parent caret, bounded count
    if (do_caret) begin
      if (st.caret_count < MAX_CARETS) begin
        grp.chars[n] = CH_CARET;
        n = n + 3'd1;
        st_next.caret_count = st.caret_count + 8'd1;
        st_next.phase       = PH_CARETS;
      end else begin
        st_next.error = 1'b1;
      end
    end

    // Name head: null, multi, dual or first byte of a single segment
    if (do_head) begin
      st_next.segment_fill = 3'd0;
      if (path_byte == CH_NUL) begin
        st_next.phase = PH_DONE;
      end else if (path_byte == CH_MULTI) begin
        st_next.phase = PH_COUNT;
      end else if (path_byte == CH_DUAL) begin
        st_next.segments_left = 8'd2;
        st_next.phase         = PH_SEGS;
      end else begin
        st_next.segments_left = 8'd1;
        st_next.phase         = PH_SEGS;
        do_seg                = 1'b1;
      end
    end

    // Segment byte: buffer, or emit the completed segment
    if (do_seg) begin
      if (st_next.segment_fill > 3'(NAME_SEG_LEN - 1)) st_next.segment_fill = 3'd0;
      if (!byte_ok(path_byte, st_next.segment_fill == 3'd0)) begin
        st_next.error = 1'b1;
      end else if (st_next.segment_fill < 3'(NAME_SEG_LEN - 1)) begin
        st_next.seg_buf[st_next.segment_fill[1:0]] = path_byte;
        st_next.segment_fill = st_next.segment_fill + 3'd1;
      end else begin
        seg_full = {path_byte, st.seg_buf};
        if (!st.first_seg) begin
          grp.chars[n] = CH_DUAL;
          n = n + 3'd1;
        end
        st_next.first_seg = 1'b0;
        // Drop trailing underscores
        if (seg_full[3] != CH_UNDER)      trim_len = 3'd4;
        else if (seg_full[2] != CH_UNDER) trim_len = 3'd3;
        else if (seg_full[1] != CH_UNDER) trim_len = 3'd2;
        else if (seg_full[0] != CH_UNDER) trim_len = 3'd1;
        else                              trim_len = 3'd0;
        for (int i = 0; i < NAME_SEG_LEN; i++) begin
          if (3'(i) < trim_len) begin
            grp.chars[n] = seg_full[i];
            n = n + 3'd1;
          end
        end
        st_next.segment_fill  = 3'd0;
        st_next.segments_left = st.segments_left - 8'd1;
        if (st_next.segments_left == 8'd0) st_next.phase = PH_DONE;
      end
    end

    // Saturating character count
    sum     = {1'b0, st.emitted_count} + 12'(n);
    emitted = (sum > {1'b0, LEN_MAX}) ? LEN_MAX : sum[10:0];
    st_next.emitted_count = emitted;

    // Terminator word closes the path and restarts the parser
    if (end_of_path) begin
      bad = st_next.error || (st_next.phase == PH_COUNT) || (st_next.phase == PH_SEGS);
      len = (emitted == LEN_MAX) ? LEN_MAX : emitted + 11'd1;
      grp.chars[n] = CH_NUL;
      n = n + 3'd1;
      grp.fin    = 1'b1;
      grp.status = bad;
      grp.length = bad ? 11'd0 : len;
      st_next    = ST_RESET;
    end

    grp.count = n;
  end

endmodule

FILE: design/aml_to_asl_name_path_decoder_top.sv
// ----------------------------------------------------------------------------
// aml_to_asl_name_path_decoder_top
// AML name path to ASL text decoder.
//
// Input channel: one path byte per word (path_byte, end_of_path, no_byte),
// handshake in_valid / in_stall. Output channel: one ASL character per word
// (out_char, final_item, status, text_length), handshake out_valid /
// out_stall. The word with final_item set carries a null character, the
// status and the text length, and closes the path.
//
// Each input word is parsed in the cycle it is taken; the words it produces
// (zero to six) are loaded into a group register, the first shown in the
// cycle after acceptance. While the receiver does not stall, they are shown
// one per cycle and a word producing at most one word is taken every cycle.
// A word producing more keeps the input stalled, since the next input word
// is taken in the cycle the last one of the group leaves; a completed
// segment produces up to five words, six when it also ends the path. When
// the receiver stalls, the current word holds and the input stalls once the
// group is in use. Reset clears the parser and drops undelivered characters.
// ----------------------------------------------------------------------------
module aml_to_asl_name_path_decoder_top
  import aml2asl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  path_byte,
  input  logic        end_of_path,
  input  logic        no_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        final_item,
  output logic        status,
  output logic [10:0] text_length
);

  state_t     st;
  state_t     st_next;
  group_t     grp_new;
  group_t     grp;
  logic [2:0] idx;
  logic       in_take;
  logic       out_take;
  logic       last_pos;

  aml2asl_step u_step (
    .st          (st),
    .path_byte   (path_byte),
    .end_of_path (end_of_path),
    .no_byte     (no_byte),
    .st_next     (st_next),
    .grp         (grp_new)
  );

  // Handshake
  assign out_valid = (grp.count != 3'd0);
  assign last_pos  = (idx == grp.count - 3'd1);
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = out_valid && !(out_take && last_pos);
  assign in_take   = in_valid && !in_stall;

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (in_take) begin
      st <= st_next;
    end
  end

  // Load a new group, step through the current one, drop it when drained
  always_ff @(posedge clk) begin
    if (rst) begin
      grp.count <= 3'd0;
      idx       <= 3'd0;
    end else if (in_take) begin
      grp.count  <= grp_new.count;
      grp.chars  <= grp_new.chars;
      grp.fin    <= grp_new.fin;
      grp.status <= grp_new.status;
      grp.length <= grp_new.length;
      idx        <= 3'd0;
    end else if (out_take) begin
      if (last_pos) begin
        grp.count <= 3'd0;
        idx       <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Output word
  assign out_char    = grp.chars[idx];
  assign final_item  = grp.fin && last_pos;
  assign status      = final_item ? grp.status : 1'b0;
  assign text_length = final_item ? grp.length : 11'd0;

endmodule

FILE: design/aml2asl_chk.sv
// ----------------------------------------------------------------------------
// aml2asl_chk
// Port-level checks for the name path decoder, bound to the top level.
// ----------------------------------------------------------------------------
module aml2asl_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  path_byte,
  input logic        end_of_path,
  input logic        no_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char,
  input logic        final_item,
  input logic        status,
  input logic [10:0] text_length
);

  // Stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(final_item))
    else $error("output word changed while stalled");

  // Nothing is shown right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Terminator carries a null character
  assert property (@(posedge clk) disable iff (rst)
    out_valid && final_item |-> out_char == 8'h00)
    else $error("terminator with non-null character");

  // Bad path reports zero length, good path at least one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && final_item |-> (status == (text_length == 11'd0)))
    else $error("status and length disagree");

  // Ordinary characters carry no status or length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_item |-> !status && text_length == 11'd0)
    else $error("status or length on a character word");

endmodule

bind aml_to_asl_name_path_decoder_top aml2asl_chk u_chk (.*);
